// ----- src/tcrq_pkg.sv -----
// Shared constants and controller/datapath interface types for the timed release queue.
package tcrq_pkg;

   localparam int SLOTS      = 16;
   localparam int IDX_W      = $clog2(SLOTS);
   localparam int MAX_LENGTH = 60;
   localparam int REF_W      = 16;
   localparam int REQ_LEN_W  = 8;
   localparam int LEN_W      = 6;
   localparam int TIME_W     = 32;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef struct packed {
      logic latch;       // capture the request, restart the slot scan
      logic min_step;    // compare one slot against the running minimum, advance
      logic advance;     // advance the due scan by one slot
      logic write_slot;  // store the latched push into the free or picked slot
      logic capture;     // move the scanned slot into the hold stage and free it
      logic emit;        // load the hold stage into the response register
      logic emit_last;   // mark the loaded response as the final one of the tick
   } tcrq_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic len_ok;
      logic has_free;
      logic scan_last;
      logic due_now;
      logic hold_valid;
      logic out_free;
   } tcrq_status_type;

endpackage

// ----- src/timed_command_release_queue_core.sv -----
// Top level of the timed command release queue: controller plus slot datapath.
//
// Usage:
//   Request channel (req_*): one request per handshake. req_cmd = push (0) stores
//   req_command_ref, req_length and req_time_ms as a fire time in the lowest free
//   slot; a length of zero or above the maximum is dropped. With every slot in use,
//   the slot with the smallest fire time (unsigned, lowest index on ties) is replaced.
//   req_cmd = tick (1) carries the current time and releases every active slot whose
//   signed difference (now - fire time) is not negative, in slot order.
//   Response channel (rsp_*): one response per released slot, rsp_last marks the
//   final release of a tick. A push or a tick with nothing due gives no response.
// Sequencing:
//   Push: latch, decide and write with a free slot; otherwise a minimum search
//   steps through the slot table, one slot per cycle, before the write. Tick:
//   latch, decide, a due scan of one slot per cycle unless the response side stalls, then a flush.
//   req_stall is high while a request is in progress; the next request can be taken
//   while the final response still waits in the output register.
// Reset: synchronous, active high; all slots become free and no response is valid.
// Stall: a stalled response holds its payload; the tick scan pauses when a second due
//   slot finds the output register still occupied.
module timed_command_release_queue_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_cmd,
   input  logic [tcrq_pkg::REF_W-1:0]      req_command_ref,
   input  logic [tcrq_pkg::REQ_LEN_W-1:0]  req_length,
   input  logic [tcrq_pkg::TIME_W-1:0]     req_time_ms,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [tcrq_pkg::REF_W-1:0]      rsp_released_ref,
   output logic [tcrq_pkg::LEN_W-1:0]      rsp_released_length,
   output logic [tcrq_pkg::TIME_W-1:0]     rsp_released_time,
   output logic                            rsp_last
);
   import tcrq_pkg::*;

   tcrq_cmd_type    cmd;
   tcrq_status_type status;

   // sequence each request: latch, decide, scan, write or release
   tcrq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // hold slot table, scan state, hold stage and output register
   tcrq_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_cmd             (req_cmd),
      .req_command_ref     (req_command_ref),
      .req_length          (req_length),
      .req_time_ms         (req_time_ms),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_released_ref    (rsp_released_ref),
      .rsp_released_length (rsp_released_length),
      .rsp_released_time   (rsp_released_time),
      .rsp_last            (rsp_last),
      .cmd                 (cmd),
      .status              (status)
   );

endmodule

// ----- src/tcrq_ctrl.sv -----
// Controller state machine sequencing pushes, minimum search and due scans.
module tcrq_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  tcrq_pkg::tcrq_status_type status,
   output tcrq_pkg::tcrq_cmd_type    cmd
);
   import tcrq_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_MIN_SCAN,
      ST_WRITE,
      ST_DUE_SCAN,
      ST_FLUSH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.is_tick) begin
               state_in = ST_DUE_SCAN;
            end else if (!status.len_ok) begin
               state_in = ST_IDLE;
            end else if (status.has_free) begin
               cmd.write_slot = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               state_in = ST_MIN_SCAN;
            end
         end
         ST_MIN_SCAN: begin
            cmd.min_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write_slot = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_DUE_SCAN: begin
            // hold the scan while a second due slot waits on a full response register
            if (!(status.due_now && status.hold_valid && !status.out_free)) begin
               cmd.advance = 1'b1;
               cmd.capture = status.due_now;
               cmd.emit    = status.due_now && status.hold_valid;
               if (status.scan_last) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!status.hold_valid) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/tcrq_datapath.sv -----
// Slot storage, scan counter, minimum tracker, hold stage and response register.
module tcrq_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_cmd,
   input  logic [tcrq_pkg::REF_W-1:0]        req_command_ref,
   input  logic [tcrq_pkg::REQ_LEN_W-1:0]    req_length,
   input  logic [tcrq_pkg::TIME_W-1:0]       req_time_ms,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [tcrq_pkg::REF_W-1:0]        rsp_released_ref,
   output logic [tcrq_pkg::LEN_W-1:0]        rsp_released_length,
   output logic [tcrq_pkg::TIME_W-1:0]       rsp_released_time,
   output logic                              rsp_last,
   input  tcrq_pkg::tcrq_cmd_type            cmd,
   output tcrq_pkg::tcrq_status_type         status
);
   import tcrq_pkg::*;

   // slot storage; payload entries are only read while their slot is active
   logic [SLOTS-1:0]  active_ff;
   logic [REF_W-1:0]  slot_ref_ff  [SLOTS];
   logic [LEN_W-1:0]  slot_len_ff  [SLOTS];
   logic [TIME_W-1:0] slot_time_ff [SLOTS];

   logic                 cmd_ff;
   logic [REF_W-1:0]     ref_ff;
   logic [REQ_LEN_W-1:0] len_ff;
   logic [TIME_W-1:0]    time_ff;

   logic [IDX_W-1:0]  idx_ff;
   logic [TIME_W-1:0] best_ff;
   logic [IDX_W-1:0]  pick_ff;

   logic              hold_valid_ff;
   logic [REF_W-1:0]  hold_ref_ff;
   logic [LEN_W-1:0]  hold_len_ff;
   logic [TIME_W-1:0] hold_time_ff;

   logic              out_valid_ff;
   logic [REF_W-1:0]  out_ref_ff;
   logic [LEN_W-1:0]  out_len_ff;
   logic [TIME_W-1:0] out_time_ff;
   logic              out_last_ff;

   logic [IDX_W-1:0]  free_idx;
   logic              has_free;
   logic [IDX_W-1:0]  wr_idx;
   logic [TIME_W-1:0] scan_time;
   logic [TIME_W-1:0] diff;
   logic              due_now;
   logic              out_free;

   // lowest free slot
   always_comb begin
      free_idx = '0;
      has_free = 1'b0;
      for (int k = SLOTS - 1; k >= 0; k--) begin
         if (!active_ff[k]) begin
            free_idx = IDX_W'(k);
            has_free = 1'b1;
         end
      end
   end

   assign wr_idx    = has_free ? free_idx : pick_ff;
   assign scan_time = slot_time_ff[idx_ff];
   assign diff      = time_ff - scan_time;
   assign due_now   = active_ff[idx_ff] && !diff[TIME_W-1];
   assign out_free  = !out_valid_ff || !rsp_stall;

   assign status.is_tick    = (cmd_ff == CMD_TICK);
   assign status.len_ok     = (len_ff != '0) && (len_ff <= REQ_LEN_W'(MAX_LENGTH));
   assign status.has_free   = has_free;
   assign status.scan_last  = (idx_ff == IDX_W'(SLOTS - 1));
   assign status.due_now    = due_now;
   assign status.hold_valid = hold_valid_ff;
   assign status.out_free   = out_free;

   // request latch, scan counter, minimum tracker
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         cmd_ff  <= req_cmd;
         ref_ff  <= req_command_ref;
         len_ff  <= req_length;
         time_ff <= req_time_ms;
         idx_ff  <= '0;
         best_ff <= '1;
         pick_ff <= '0;
      end else begin
         if (cmd.min_step || cmd.advance) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.min_step && (scan_time < best_ff)) begin
            best_ff <= scan_time;
            pick_ff <= idx_ff;
         end
      end
   end

   // slot payload
   always_ff @(posedge clock) begin
      if (cmd.write_slot) begin
         slot_ref_ff[wr_idx]  <= ref_ff;
         slot_len_ff[wr_idx]  <= len_ff[LEN_W-1:0];
         slot_time_ff[wr_idx] <= time_ff;
      end
   end

   // hold stage and response payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         hold_ref_ff  <= slot_ref_ff[idx_ff];
         hold_len_ff  <= slot_len_ff[idx_ff];
         hold_time_ff <= scan_time;
      end
      if (cmd.emit) begin
         out_ref_ff  <= hold_ref_ff;
         out_len_ff  <= hold_len_ff;
         out_time_ff <= hold_time_ff;
         out_last_ff <= cmd.emit_last;
      end
   end

   // control bits
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (cmd.write_slot) begin
            active_ff[wr_idx] <= 1'b1;
         end
         if (cmd.capture) begin
            active_ff[idx_ff] <= 1'b0;
         end
         if (cmd.capture) begin
            hold_valid_ff <= 1'b1;
         end else if (cmd.emit) begin
            hold_valid_ff <= 1'b0;
         end
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_released_ref    = out_ref_ff;
   assign rsp_released_length = out_len_ff;
   assign rsp_released_time   = out_time_ff;
   assign rsp_last            = out_last_ff;

endmodule

// ----- src/tcrq_checker.sv -----
// Port-level assertions for the timed command release queue, bound to the top level.
module tcrq_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [tcrq_pkg::REF_W-1:0]      rsp_released_ref,
   input logic [tcrq_pkg::LEN_W-1:0]      rsp_released_length,
   input logic [tcrq_pkg::TIME_W-1:0]     rsp_released_time,
   input logic                            rsp_last
);
   import tcrq_pkg::*;

   // a stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_released_ref)
         && $stable(rsp_released_length) && $stable(rsp_released_time)
         && $stable(rsp_last))
      else $error("response changed while stalled");

   // every accepted request makes the block busy in the following cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted without entering a busy state");

   // a new response is only loaded while a tick is being worked on
   a_rsp_in_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response appeared without a tick in progress");

   // reset leaves no response pending
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind timed_command_release_queue_core tcrq_checker u_tcrq_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_released_ref    (rsp_released_ref),
   .rsp_released_length (rsp_released_length),
   .rsp_released_time   (rsp_released_time),
   .rsp_last            (rsp_last)
);
